@@ rtl/ffha_pkg.sv @@
// shared types and constants for the first-fit heap allocator
package ffha_pkg;

  localparam int HEAP_WORDS = 4096;
  localparam int ADDR_W     = $clog2(HEAP_WORDS);
  localparam int PTR_W      = ADDR_W + 1;
  localparam int SIZE_W     = 12;
  localparam int CFG_W      = 13;
  localparam int MODE_W     = 2;
  localparam int MIN_WORDS  = 16;
  localparam int SPLIT_MIN  = 2;

  localparam logic [MODE_W-1:0] MODE_FORMAT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FREE   = 2'd2;

  typedef struct packed {
    logic              used;
    logic [SIZE_W-1:0] size;
  } hdr_t;

  // header 0 right after reset: one free part over the whole default heap
  localparam hdr_t RESET_HDR = '{used: 1'b0, size: SIZE_W'(HEAP_WORDS - 1)};

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    hdr_t              wr_data;
  } mem_req_t;

endpackage

@@ rtl/ffha_hdr_store.sv @@
// part header memory with reset value for header 0
module ffha_hdr_store (
  input  logic              clk,
  input  logic              rst,
  input  ffha_pkg::mem_req_t req,
  output ffha_pkg::hdr_t    rd_data
);
  import ffha_pkg::*;

  hdr_t mem [HEAP_WORDS];
  hdr_t q;
  logic rd_at_zero;
  logic zero_written;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      q          <= mem[req.rd_addr];
      rd_at_zero <= (req.rd_addr == '0);
    end
  end

  // header 0 holds its reset value until first written
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_written <= 1'b0;
    end else if (req.wr_en && req.wr_addr == '0) begin
      zero_written <= 1'b1;
    end
  end

  assign rd_data = (rd_at_zero && !zero_written) ? RESET_HDR : q;

endmodule

@@ rtl/first_fit_heap_allocator.sv @@
// top level of the first-fit heap allocator
//
// usage: one heap of part headers, each a used flag and a 12-bit size.
// input channel (in_valid/in_ready) carries one beat per command: mode,
// request_words, block_offset. output channel (out_valid/out_ready) returns
// one beat per command: data_offset and granted.
// cfg_we/cfg_wdata write heap_words at any edge; only while idle is defined.
// states from input beat to result beat, all leaving IDLE and ending in DONE:
//   format: FMT; free: FREE_RD, FREE_WR; unused mode or bad free: none between;
//   allocate: WALK_RD, then WALK once per part visited by the walk, SPLIT when split.
// the walk reads one header per cycle through the single header memory port
// and one add/compare unit; in_ready is high only while the sequencer idles.
// a finished result sits in the output register; a new beat may be taken
// while it waits, and the next result waits in DONE until out_ready frees it.
// reset: heap_words returns to 4096 and header 0 reads as one free part of
// 4095 words; no clearing pass, the rest of the memory is undefined.
module first_fit_heap_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ffha_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ffha_pkg::MODE_W-1:0]   mode,
  input  logic [ffha_pkg::SIZE_W-1:0]   request_words,
  input  logic [ffha_pkg::SIZE_W-1:0]   block_offset,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ffha_pkg::SIZE_W-1:0]   data_offset,
  output logic                          granted
);
  import ffha_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_FMT, S_WALK_RD, S_WALK, S_SPLIT, S_FREE_RD, S_FREE_WR, S_DONE
  } state_t;

  state_t            state;
  logic [CFG_W-1:0]  heap_words;
  logic [PTR_W-1:0]  eff_words;

  // latched command
  logic [SIZE_W-1:0] req;
  logic [ADDR_W-1:0] free_addr;

  // walk registers
  logic [PTR_W-1:0]  p;
  logic [PTR_W-1:0]  run;
  logic              have;
  logic [ADDR_W-1:0] start;
  logic [ADDR_W-1:0] split_addr;
  logic [SIZE_W-1:0] split_size;

  // pending result
  logic [SIZE_W-1:0] res_offset;
  logic              res_granted;

  mem_req_t          mreq;
  hdr_t              hdr;

  ffha_hdr_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (mreq),
    .rd_data (hdr)
  );

  // clamp the register to the legal heap range
  always_comb begin
    if (heap_words < CFG_W'(MIN_WORDS)) begin
      eff_words = PTR_W'(MIN_WORDS);
    end else if (heap_words > CFG_W'(HEAP_WORDS)) begin
      eff_words = PTR_W'(HEAP_WORDS);
    end else begin
      eff_words = PTR_W'(heap_words);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_words <= CFG_W'(HEAP_WORDS);
    end else if (cfg_we) begin
      heap_words <= cfg_wdata;
    end
  end

  // free range check on the incoming beat
  logic [ADDR_W-1:0] in_free_addr;
  logic              in_free_ok;
  assign in_free_addr = ADDR_W'(block_offset - 1'b1);
  assign in_free_ok   = (block_offset != '0) &&
                        (PTR_W'(in_free_addr) < eff_words);

  // shared walk unit: clip the part, extend the run, step to the next header
  logic [PTR_W-1:0]  hw_left;
  logic [PTR_W-1:0]  s_raw;
  logic [PTR_W-1:0]  s_eff;
  logic              last;
  logic              have_next;
  logic [PTR_W-1:0]  run_next;
  logic [ADDR_W-1:0] start_next;
  logic [PTR_W-1:0]  p_next;
  logic              fit;
  logic [PTR_W-1:0]  spare;
  logic              do_split;
  logic              walk_end;

  always_comb begin
    hw_left    = eff_words - p;
    s_raw      = PTR_W'(hdr.size);
    last       = (s_raw >= hw_left);
    s_eff      = last ? (hw_left - 1'b1) : s_raw;
    p_next     = p + s_eff + 1'b1;
    if (hdr.used) begin
      have_next  = 1'b0;
      run_next   = '0;
      start_next = start;
    end else if (have) begin
      have_next  = 1'b1;
      run_next   = run + s_eff + 1'b1;
      start_next = start;
    end else begin
      have_next  = 1'b1;
      run_next   = s_eff;
      start_next = p[ADDR_W-1:0];
    end
    fit        = have_next && (run_next >= PTR_W'(req));
    spare      = run_next - PTR_W'(req);
    do_split   = (spare > PTR_W'(SPLIT_MIN));
    walk_end   = last || (p_next >= eff_words);
  end

  // header memory requests
  always_comb begin
    mreq = '0;
    case (state)
      S_FMT: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = '0;
        mreq.wr_data = '{used: 1'b0, size: SIZE_W'(eff_words - 1'b1)};
      end
      S_WALK_RD: begin
        mreq.rd_en   = 1'b1;
        mreq.rd_addr = p[ADDR_W-1:0];
      end
      S_WALK: begin
        if (fit) begin
          mreq.wr_en   = 1'b1;
          mreq.wr_addr = start_next;
          mreq.wr_data = '{used: 1'b1,
                           size: do_split ? req : SIZE_W'(run_next)};
        end else if (!walk_end) begin
          // fetch the next header straight away
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = p_next[ADDR_W-1:0];
        end
      end
      S_SPLIT: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = split_addr;
        mreq.wr_data = '{used: 1'b0, size: split_size};
      end
      S_FREE_RD: begin
        mreq.rd_en   = 1'b1;
        mreq.rd_addr = free_addr;
      end
      S_FREE_WR: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = free_addr;
        mreq.wr_data = '{used: 1'b0, size: hdr.size};
      end
      default: begin
        mreq = '0;
      end
    endcase
  end

  assign in_ready = (state == S_IDLE);

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // in DONE the output register is reloaded below instead
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req         <= request_words;
            free_addr   <= in_free_addr;
            res_offset  <= '0;
            res_granted <= 1'b0;
            p           <= '0;
            run         <= '0;
            have        <= 1'b0;
            start       <= '0;
            case (mode)
              MODE_FORMAT: state <= S_FMT;
              MODE_ALLOC:  state <= S_WALK_RD;
              MODE_FREE:   state <= in_free_ok ? S_FREE_RD : S_DONE;
              default:     state <= S_DONE;
            endcase
          end
        end
        S_FMT: begin
          res_granted <= 1'b1;
          state       <= S_DONE;
        end
        S_WALK_RD: begin
          state <= S_WALK;
        end
        S_WALK: begin
          run   <= run_next;
          have  <= have_next;
          start <= start_next;
          p     <= p_next;
          if (fit) begin
            res_offset  <= start_next + 1'b1;
            res_granted <= 1'b1;
            split_addr  <= start_next + ADDR_W'(req) + 1'b1;
            split_size  <= SIZE_W'(spare - 1'b1);
            state       <= do_split ? S_SPLIT : S_DONE;
          end else if (walk_end) begin
            state <= S_DONE;
          end
        end
        S_SPLIT: begin
          state <= S_DONE;
        end
        S_FREE_RD: begin
          state <= S_FREE_WR;
        end
        S_FREE_WR: begin
          res_granted <= 1'b1;
          state       <= S_DONE;
        end
        S_DONE: begin
          // hand over once the output register is free
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            data_offset <= res_offset;
            granted     <= res_granted;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ tb/ffha_checker.sv @@
`timescale 1ns / 100ps
// result checker and header model for the first-fit heap allocator testbench
module ffha_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ffha_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [ffha_pkg::MODE_W-1:0]       mode,
  input  logic [ffha_pkg::SIZE_W-1:0]       request_words,
  input  logic [ffha_pkg::SIZE_W-1:0]       block_offset,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [ffha_pkg::SIZE_W-1:0]       data_offset,
  input  logic                              granted,
  output int                                fail_count,
  output int                                grants_owed,
  output logic [ffha_pkg::HEAP_WORDS-1:0]   hdr_written,
  output logic [ffha_pkg::HEAP_WORDS-1:0]   hdr_used
);
  import ffha_pkg::*;

  typedef struct packed {
    logic [SIZE_W-1:0] data_offset;
    logic              granted;
  } heap_reply_t;

  hdr_t              heap_hdr [HEAP_WORDS];
  logic [CFG_W-1:0]  heap_words_q;
  heap_reply_t       pending_replies [$];

  function automatic int active_words();
    int w;
    w = heap_words_q;
    if (w < MIN_WORDS) w = MIN_WORDS;
    if (w > HEAP_WORDS) w = HEAP_WORDS;
    return w;
  endfunction

  task automatic put_hdr(input int idx, input logic used, input int size);
    heap_hdr[idx].used = used;
    heap_hdr[idx].size = size[SIZE_W-1:0];
    hdr_written[idx]   = 1'b1;
    hdr_used[idx]      = used;
  endtask

  // model of format, free and the first-fit walk with merging of free neighbors
  task automatic apply_heap_op(input logic [MODE_W-1:0] op, input int req, input int off);
    heap_reply_t reply;
    int          hw;
    int          p;
    int          run;
    int          start;
    int          s;
    int          total;
    bit          have;
    bit          last;
    bit          done;
    hw    = active_words();
    reply = '0;
    case (op)
      MODE_FORMAT: begin
        put_hdr(0, 1'b0, hw - 1);
        reply.granted = 1'b1;
      end
      MODE_ALLOC: begin
        p     = 0;
        run   = -1;
        start = 0;
        have  = 0;
        done  = 0;
        while (p < hw && !done) begin
          s    = heap_hdr[p].size;
          last = 0;
          // part reaching past the heap end is clipped and closes the walk
          if (s >= hw - p) begin
            s    = hw - 1 - p;
            last = 1;
          end
          if (heap_hdr[p].used) begin
            run  = -1;
            have = 0;
          end else begin
            run = run + s + 1;
            if (!have) begin
              have  = 1;
              start = p;
            end
          end
          if (have && run >= req) begin
            total = run;
            if (total - req > SPLIT_MIN) begin
              put_hdr(start, 1'b1, req);
              put_hdr(start + req + 1, 1'b0, total - req - 1);
            end else begin
              put_hdr(start, 1'b1, total);
            end
            reply.data_offset = SIZE_W'(start + 1);
            reply.granted     = 1'b1;
            done              = 1;
          end else if (last) begin
            done = 1;
          end else begin
            p = p + s + 1;
          end
        end
      end
      MODE_FREE: begin
        if (off != 0 && off - 1 < hw) begin
          put_hdr(off - 1, 1'b0, heap_hdr[off - 1].size);
          reply.granted = 1'b1;
        end
      end
      default: ;
    endcase
    pending_replies.push_back(reply);
  endtask

  always @(posedge clk) begin
    heap_reply_t want;
    if (rst) begin
      heap_words_q   = CFG_W'(HEAP_WORDS);
      hdr_written    = '0;
      hdr_used       = '0;
      heap_hdr[0]    = RESET_HDR;
      hdr_written[0] = 1'b1;
      pending_replies.delete();
    end else begin
      if (cfg_we) heap_words_q = cfg_wdata;
      if (out_valid && out_ready) begin
        if (pending_replies.size() == 0) begin
          $display("%0t result beat: expected none, actual data_offset %0d granted %0d",
                   $time, data_offset, granted);
          fail_count++;
        end else begin
          want = pending_replies.pop_front();
          if (data_offset !== want.data_offset) begin
            $display("%0t data_offset: expected %0d, actual %0d",
                     $time, want.data_offset, data_offset);
            fail_count++;
          end
          if (granted !== want.granted) begin
            $display("%0t granted: expected %0d, actual %0d", $time, want.granted, granted);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        apply_heap_op(mode, int'(request_words), int'(block_offset));
      end
    end
    grants_owed = pending_replies.size();
  end

endmodule

@@ tb/first_fit_heap_allocator_tb.sv @@
`timescale 1ns / 100ps
// testbench top: clock, reset, stimulus and verdict for the first-fit heap allocator
module first_fit_heap_allocator_tb;
  import ffha_pkg::*;

  // mode 3 has no meaning in the block
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  // cycles with no beat on either channel before the run is declared hung;
  // a full walk of a fragmented heap plus the longest stall stays far below
  localparam int IDLE_LIMIT   = 20000;
  localparam int PHASE_ITEMS  = 200;
  localparam int PHASE_COUNT  = 10;

  logic                clk           = 1'b0;
  logic                rst           = 1'b1;
  logic                cfg_we        = 1'b0;
  logic [CFG_W-1:0]    cfg_wdata     = '0;
  logic                in_valid      = 1'b0;
  logic                in_ready;
  logic [MODE_W-1:0]   mode          = '0;
  logic [SIZE_W-1:0]   request_words = '0;
  logic [SIZE_W-1:0]   block_offset  = '0;
  logic                out_valid;
  logic                out_ready     = 1'b0;
  logic [SIZE_W-1:0]   data_offset;
  logic                granted;

  int                  fail_count;
  int                  grants_owed;
  logic [HEAP_WORDS-1:0] hdr_written;
  logic [HEAP_WORDS-1:0] hdr_used;

  // raw register value as last written, and the heap extent that the part
  // chain is known to cover; growing past it without a format would walk
  // into header words that were never written
  int                  heap_words_raw = HEAP_WORDS;
  int                  chain_span     = HEAP_WORDS;
  // phases with no idling on either side
  bit                  quiet          = 1'b0;
  int                  idle_cycles    = 0;

  // settings swept by the random phases: extremes, clamped values and odd sizes
  int phase_words [PHASE_COUNT] = '{4096, 16, 300, 0, 8191, 1000, 17, 4096, 4095, 2048};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  first_fit_heap_allocator u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .request_words (request_words),
    .block_offset  (block_offset),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .data_offset   (data_offset),
    .granted       (granted)
  );

  ffha_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .request_words (request_words),
    .block_offset  (block_offset),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .data_offset   (data_offset),
    .granted       (granted),
    .fail_count    (fail_count),
    .grants_owed   (grants_owed),
    .hdr_written   (hdr_written),
    .hdr_used      (hdr_used)
  );

  function automatic int clamp_words(input int raw);
    if (raw < MIN_WORDS) return MIN_WORDS;
    if (raw > HEAP_WORDS) return HEAP_WORDS;
    return raw;
  endfunction

  // mostly back to back, sometimes a few cycles, rarely a long hole
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 200);
  endfunction

  // small requests keep the heap busy with many parts; a few large ones hit no-fit
  function automatic int pick_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(0, 15);
    if (r < 90) return $urandom_range(16, 200);
    if (r < 97) return $urandom_range(201, 4095);
    return (r[0]) ? 4095 : 0;
  endfunction

  // free targets: live used headers mostly, then any written word (stale
  // headers and data words), offset zero, and offsets past the heap end.
  // a word never written is never picked, its content is undefined
  function automatic int pick_free(input int hw);
    int r;
    int lim;
    int start;
    int i;
    r   = $urandom_range(0, 99);
    lim = (hw < 4095) ? hw : 4095;
    if (r < 85) begin
      start = $urandom_range(0, lim - 1);
      for (int k = 0; k < lim; k++) begin
        i = (start + k) % lim;
        if (hdr_written[i] && (r >= 70 || hdr_used[i])) return i + 1;
      end
      return 1;
    end
    if (r < 92 || hw > 4094) return 0;
    return $urandom_range(hw + 1, 4095);
  endfunction

  // idle cycles with valid low, ending on a falling edge
  task automatic open_slot(input int gap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // present one beat and hold it until accepted
  task automatic push_beat(input logic [MODE_W-1:0] m, input int req, input int off);
    mode          = m;
    request_words = req[SIZE_W-1:0];
    block_offset  = off[SIZE_W-1:0];
    in_valid      = 1'b1;
    if (m == MODE_FORMAT) chain_span = clamp_words(heap_words_raw);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic run_item(input logic [MODE_W-1:0] m, input int req, input int off);
    open_slot(pick_gap());
    push_beat(m, req, off);
  endtask

  // stop sending and wait until every result has come back
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (grants_owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // new heap size while idle; keep_layout leaves the parts in place where the
  // chain still covers the new extent, otherwise a format follows at once
  task automatic set_heap_words(input int raw, input bit keep_layout);
    drain();
    cfg_wdata      = raw[CFG_W-1:0];
    cfg_we         = 1'b1;
    @(negedge clk);
    cfg_we         = 1'b0;
    heap_words_raw = raw;
    if (keep_layout && clamp_words(raw) <= chain_span) begin
      chain_span = clamp_words(raw);
    end else begin
      run_item(MODE_FORMAT, $urandom_range(0, 4095), $urandom_range(0, 4095));
    end
  endtask

  task automatic random_item();
    int r;
    int hw;
    int rq;
    int off;
    logic [MODE_W-1:0] m;
    open_slot(pick_gap());
    // picked at the falling edge, after the previous beat reached the model
    hw  = clamp_words(heap_words_raw);
    rq  = $urandom_range(0, 4095);
    off = $urandom_range(0, 4095);
    r   = $urandom_range(0, 99);
    if (r < 50) begin
      m  = MODE_ALLOC;
      rq = pick_request();
    end else if (r < 88) begin
      m   = MODE_FREE;
      off = pick_free(hw);
    end else if (r < 93) begin
      m = MODE_FORMAT;
    end else if (r < 96) begin
      m = MODE_UNUSED;
    end else begin
      m  = MODE_ALLOC;
      rq = $urandom_range(hw / 2, 4095);
    end
    push_beat(m, rq, off);
  endtask

  // receiver: ready runs broken by stalls of random length
  initial begin
    int gap;
    wait (!rst);
    forever begin
      @(negedge clk);
      out_ready = 1'b1;
      repeat ($urandom_range(1, 20)) @(negedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  // watchdog: any beat on either channel restarts the count
  initial begin
    wait (!rst);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // directed part at the reset size of 4096 words
    run_item(MODE_ALLOC, 0, 4095);       // zero request, splits the whole heap
    run_item(MODE_ALLOC, 4095, 0);       // largest request, no fit
    run_item(MODE_ALLOC, 10, 0);
    run_item(MODE_FREE, 0, 1);           // free the zero-word part
    run_item(MODE_FREE, 4095, 0);        // offset zero is ignored
    run_item(MODE_UNUSED, 4095, 4095);   // unused mode
    run_item(MODE_ALLOC, 0, 0);          // zero-size free part fits exactly
    run_item(MODE_FREE, 0, 2);
    run_item(MODE_FREE, 0, 1);
    run_item(MODE_ALLOC, 11, 0);         // two free neighbors merged, taken whole
    run_item(MODE_FREE, 0, 2);           // stale header inside a used part
    run_item(MODE_FORMAT, 0, 0);
    run_item(MODE_ALLOC, 4094, 0);       // whole heap in one part
    run_item(MODE_ALLOC, 0, 0);          // heap full
    run_item(MODE_FORMAT, 0, 0);
    run_item(MODE_ALLOC, 4092, 0);       // remainder of three words still splits
    run_item(MODE_ALLOC, 2, 0);          // remainder part taken whole at heap end

    // shrink without format: the first part now reaches past the heap end
    set_heap_words(64, 1'b1);
    run_item(MODE_ALLOC, 5, 0);          // clipped part is used, no fit
    run_item(MODE_FREE, 0, 1);
    run_item(MODE_ALLOC, 40, 0);         // clipped free part split
    run_item(MODE_FREE, 0, 65);          // header at the heap end, ignored
    run_item(MODE_FREE, 0, 4095);
    run_item(MODE_ALLOC, 22, 0);

    // below the minimum clamps to 16 words
    set_heap_words(0, 1'b1);
    run_item(MODE_ALLOC, 0, 0);
    run_item(MODE_FREE, 0, 17);

    // above the maximum clamps to 4096, formatted on the way up
    set_heap_words(8191, 1'b0);
    run_item(MODE_ALLOC, 4095, 0);
    run_item(MODE_ALLOC, 0, 0);

    // random phases, each at its own heap size
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      quiet = (ph == 3 || ph == 7);
      set_heap_words(phase_words[ph], ph % 3 == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // sender holds off now and then until every result is back
        if (n == PHASE_ITEMS / 2 || $urandom_range(0, 199) == 0) drain();
        random_item();
      end
    end

    drain();
    repeat (64) @(negedge clk);
    if (fail_count == 0 && grants_owed == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
